### sv/vma_pkg.sv
`timescale 1ns / 1ps
// Package for the per-vertex missing transverse energy accumulator.
// Holds sizes, command and state codes, the queue transaction type and arithmetic helpers.
// Depends on nothing.
package vma_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int NVAR         = 3;
    localparam int NSLOT        = MAX_VERTICES * NVAR;
    localparam int SLOT_W       = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int VTX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
    localparam int IN_W         = 16;
    localparam int ETA_W        = 11;
    localparam int SUM_W        = 28;
    localparam int SQ_W         = 2 * SUM_W;
    localparam int REM_W        = SUM_W + 3;
    localparam int ROOT_ITERS   = SUM_W;
    localparam int ITER_W       = $clog2(ROOT_ITERS);
    localparam int RAM_W        = 4 * SUM_W;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_W        = 16;
    localparam int ETA_CUT_W    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_DZ_CUT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ETA      = 2'd2;
    localparam logic [15:0]          DZ_CUT_RESET     = 16'd100;
    localparam logic [15:0]          MIN_PT_RESET     = 16'd0;
    localparam logic [9:0]           MAX_ETA_RESET    = 10'd1023;

    localparam logic [1:0] VAR_FULL  = 2'd0;
    localparam logic [1:0] VAR_TRACK = 2'd1;
    localparam logic [1:0] VAR_NOPU  = 2'd2;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NO_VERTEX = 1'b1;

    localparam logic signed [SUM_W-1:0] SMAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SMIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [SUM_W-1:0]        UMAX = {SUM_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_CAND = 2'd1,
        CMD_EMIT = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SEARCH,
        B_UPDATE,
        B_EMIT_RD,
        B_EMIT_NEG,
        B_EMIT_SQ,
        B_EMIT_SUM,
        B_ROOT,
        B_OUT,
        B_NONE
    } back_state_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic signed [IN_W-1:0] vertex_z;
        logic signed [IN_W-1:0] px;
        logic signed [IN_W-1:0] py;
        logic signed [IN_W-1:0] pz;
        logic [IN_W-1:0]        pt;
        logic                   charged;
        logic                   tk;
        logic signed [IN_W-1:0] cz;
        logic [IN_W-1:0]        dz_cut;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic signed [SUM_W-1:0] sat_add_s(
        input logic signed [SUM_W-1:0] a,
        input logic signed [IN_W-1:0]  b
    );
        logic signed [SUM_W:0] s;
        s = $signed({a[SUM_W-1], a}) + $signed({{(SUM_W+1-IN_W){b[IN_W-1]}}, b});
        if (s[SUM_W] != s[SUM_W-1])
            return s[SUM_W] ? SMIN : SMAX;
        return s[SUM_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_add_u(
        input logic [SUM_W-1:0] a,
        input logic [IN_W-1:0]  b
    );
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W+1-IN_W){1'b0}}, b};
        return s[SUM_W] ? UMAX : s[SUM_W-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_neg(input logic signed [SUM_W-1:0] a);
        return (a == SMIN) ? SMAX : -a;
    endfunction

endpackage

### sv/vma_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module vma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/vma_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, command acceptance and candidate classification.
// Depends on vma_pkg.
module vma_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [1:0]                   cmd,
    input  logic signed [15:0]           vertex_z,
    input  logic signed [15:0]           cand_px,
    input  logic signed [15:0]           cand_py,
    input  logic signed [15:0]           cand_pz,
    input  logic [15:0]                  cand_pt,
    input  logic signed [10:0]           cand_eta,
    input  logic                         is_charged,
    input  logic signed [15:0]           cand_z,
    input  logic                         cfg_we,
    input  logic [vma_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vma_pkg::CFG_W-1:0]    cfg_data,
    input  vma_pkg::q_status_t           q_status,
    output logic                         busy,
    output logic                         push,
    output vma_pkg::item_t               push_item
);

    logic [15:0] dz_cut_reg;
    logic [15:0] min_pt_reg;
    logic [9:0]  max_eta_reg;
    logic [10:0] eta_abs;
    vma_pkg::cmd_t cmd_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_cut_reg  <= vma_pkg::DZ_CUT_RESET;
            min_pt_reg  <= vma_pkg::MIN_PT_RESET;
            max_eta_reg <= vma_pkg::MAX_ETA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vma_pkg::CFG_DZ_CUT:  dz_cut_reg  <= cfg_data;
                vma_pkg::CFG_MIN_PT:  min_pt_reg  <= cfg_data;
                vma_pkg::CFG_MAX_ETA: max_eta_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // -(-1024) wraps to 1024 as an unsigned 11-bit value
    assign eta_abs  = cand_eta[10] ? 11'(-cand_eta) : 11'(cand_eta);
    assign cmd_code = vma_pkg::cmd_t'(cmd);
    assign busy     = q_status.full;

    // drop the unused command here
    assign push = start && !q_status.full && (cmd_code != vma_pkg::CMD_NOP);

    always_comb
    begin
        push_item.cmd      = cmd_code;
        push_item.vertex_z = vertex_z;
        push_item.px       = cand_px;
        push_item.py       = cand_py;
        push_item.pz       = cand_pz;
        push_item.pt       = cand_pt;
        push_item.charged  = is_charged;
        push_item.tk       = (cand_pt > min_pt_reg) && (eta_abs < {1'b0, max_eta_reg});
        push_item.cz       = cand_z;
        push_item.dz_cut   = dz_cut_reg;
    end

endmodule

### sv/vma_queue.sv
`timescale 1ns / 1ps
// Short transaction queue between front end and back end.
// Depends on vma_pkg.
module vma_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  vma_pkg::item_t     push_item,
    input  logic               pop,
    output vma_pkg::item_t     head,
    output vma_pkg::q_status_t status
);

    vma_pkg::item_t                  entry_reg [vma_pkg::QUEUE_DEPTH];
    logic [vma_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [vma_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [vma_pkg::QCNT_W-1:0]      count_reg;
    logic                            do_push;
    logic                            do_pop;

    function automatic logic [vma_pkg::QPTR_W-1:0] ptr_inc(
        input logic [vma_pkg::QPTR_W-1:0] p
    );
        return (p == vma_pkg::QPTR_W'(vma_pkg::QUEUE_DEPTH - 1)) ?
               '0 : p + vma_pkg::QPTR_W'(1);
    endfunction

    assign status.full  = (count_reg == vma_pkg::QCNT_W'(vma_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + vma_pkg::QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - vma_pkg::QCNT_W'(1);
        end
    end

endmodule

### sv/vma_back.sv
`timescale 1ns / 1ps
// Back end: vertex store, sum memory, nearest-vertex search, emit and square root.
// Depends on vma_pkg and vma_ram.
module vma_back (
    input  logic               clk,
    input  logic               rst_n,
    input  vma_pkg::item_t     head,
    input  vma_pkg::q_status_t q_status,
    output logic               pop,
    output logic               result_valid,
    output logic [3:0]         vertex_index,
    output logic [1:0]         variant,
    output logic signed [27:0] miss_x,
    output logic signed [27:0] miss_y,
    output logic signed [27:0] miss_z,
    output logic [27:0]        miss_mag,
    output logic [27:0]        scalar_sum,
    output logic               status,
    output logic               last
);

    localparam int SW = vma_pkg::SUM_W;

    vma_pkg::back_state_t state_reg, state_next;
    vma_pkg::item_t       item_reg;

    logic [vma_pkg::VCNT_W-1:0]  vcnt_reg;
    logic signed [15:0]          vstore_reg [vma_pkg::MAX_VERTICES];
    logic [vma_pkg::VTX_W-1:0]   v_reg;
    logic [1:0]                  k_reg;
    logic [vma_pkg::SLOT_W-1:0]  slot_reg;
    logic [vma_pkg::VTX_W-1:0]   best_reg;
    logic [15:0]                 bd_reg;
    logic [vma_pkg::NSLOT-1:0]   valid_reg;
    logic                        valid_q_reg;
    logic                        wr_pend_reg;
    logic [vma_pkg::SLOT_W-1:0]  wr_slot_reg;

    logic signed [SW-1:0]        mx_reg, my_reg, mz_reg;
    logic [SW-1:0]               pt_out_reg;
    logic signed [vma_pkg::SQ_W-1:0] sq_x_reg, sq_y_reg;
    logic [vma_pkg::SQ_W-1:0]    n_reg;
    logic [SW-1:0]               root_reg;
    logic [vma_pkg::REM_W-1:0]   rem_reg;
    logic [vma_pkg::ITER_W-1:0]  iter_reg;

    logic                        ram_we;
    logic [vma_pkg::RAM_W-1:0]   ram_wdata, ram_rdata, rd_masked;
    logic signed [SW-1:0]        s_x, s_y, s_z;
    logic [SW-1:0]               s_pt;

    logic                        last_vtx, last_slot, hit, add_en;
    logic signed [16:0]          dz_diff;
    logic [15:0]                 dz_abs;
    logic [vma_pkg::REM_W-1:0]   rem_shift, trial;

    vma_ram #(
        .WIDTH (vma_pkg::RAM_W),
        .DEPTH (vma_pkg::NSLOT)
    ) u_sum_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_slot_reg),
        .wdata (ram_wdata),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // entries not written since the last clear read as zero
    assign rd_masked = valid_q_reg ? ram_rdata : '0;
    assign {s_x, s_y, s_z, s_pt} = rd_masked;

    assign ram_we    = wr_pend_reg;
    assign ram_wdata = {vma_pkg::sat_add_s(s_x, item_reg.px),
                        vma_pkg::sat_add_s(s_y, item_reg.py),
                        vma_pkg::sat_add_s(s_z, item_reg.pz),
                        vma_pkg::sat_add_u(s_pt, item_reg.pt)};

    assign last_vtx  = (vma_pkg::VCNT_W'(v_reg) == vcnt_reg - vma_pkg::VCNT_W'(1));
    assign last_slot = last_vtx && (k_reg == 2'(vma_pkg::NVAR - 1));
    assign hit       = (bd_reg < item_reg.dz_cut);

    assign dz_diff = $signed({item_reg.cz[15], item_reg.cz})
                   - $signed({vstore_reg[v_reg][15], vstore_reg[v_reg]});
    assign dz_abs  = dz_diff[16] ? 16'(-dz_diff) : dz_diff[15:0];

    always_comb
    begin
        if (k_reg == vma_pkg::VAR_FULL)
            add_en = 1'b1;
        else if (item_reg.charged)
            add_en = hit && (v_reg == best_reg);
        else if (k_reg == vma_pkg::VAR_TRACK)
            add_en = item_reg.tk;
        else
            add_en = 1'b1;
    end

    assign rem_shift = {rem_reg[vma_pkg::REM_W-3:0], n_reg[vma_pkg::SQ_W-1 -: 2]};
    assign trial     = vma_pkg::REM_W'({root_reg, 2'b01});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= vma_pkg::B_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        unique case (state_reg)
            vma_pkg::B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    case (head.cmd)
                        vma_pkg::CMD_CAND:
                        begin
                            if (vcnt_reg != '0)
                                state_next = head.charged ? vma_pkg::B_SEARCH
                                                          : vma_pkg::B_UPDATE;
                        end
                        vma_pkg::CMD_EMIT:
                            state_next = (vcnt_reg == '0) ? vma_pkg::B_NONE
                                                          : vma_pkg::B_EMIT_RD;
                        default: ;
                    endcase
                end
            end
            vma_pkg::B_SEARCH:   if (last_vtx) state_next = vma_pkg::B_UPDATE;
            vma_pkg::B_UPDATE:   if (last_slot) state_next = vma_pkg::B_IDLE;
            vma_pkg::B_EMIT_RD:  state_next = vma_pkg::B_EMIT_NEG;
            vma_pkg::B_EMIT_NEG: state_next = vma_pkg::B_EMIT_SQ;
            vma_pkg::B_EMIT_SQ:  state_next = vma_pkg::B_EMIT_SUM;
            vma_pkg::B_EMIT_SUM: state_next = vma_pkg::B_ROOT;
            vma_pkg::B_ROOT:
                if (iter_reg == vma_pkg::ITER_W'(vma_pkg::ROOT_ITERS - 1))
                    state_next = vma_pkg::B_OUT;
            vma_pkg::B_OUT:
                state_next = last_slot ? vma_pkg::B_IDLE : vma_pkg::B_EMIT_RD;
            vma_pkg::B_NONE:     state_next = vma_pkg::B_IDLE;
            default:             state_next = vma_pkg::B_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg     <= '0;
            valid_reg    <= '0;
            wr_pend_reg  <= 1'b0;
            result_valid <= 1'b0;
            v_reg        <= '0;
            k_reg        <= '0;
            slot_reg     <= '0;
        end
        else
        begin
            wr_pend_reg  <= 1'b0;
            result_valid <= (state_reg == vma_pkg::B_OUT) || (state_reg == vma_pkg::B_NONE);
            if (wr_pend_reg)
                valid_reg[wr_slot_reg] <= 1'b1;
            unique case (state_reg) inside
                vma_pkg::B_IDLE:
                begin
                    v_reg    <= '0;
                    k_reg    <= '0;
                    slot_reg <= '0;
                    if (pop && head.cmd == vma_pkg::CMD_LOAD &&
                        vcnt_reg < vma_pkg::VCNT_W'(vma_pkg::MAX_VERTICES))
                        vcnt_reg <= vcnt_reg + vma_pkg::VCNT_W'(1);
                end
                vma_pkg::B_SEARCH:
                    v_reg <= last_vtx ? '0 : v_reg + vma_pkg::VTX_W'(1);
                vma_pkg::B_UPDATE, vma_pkg::B_OUT:
                begin
                    if (state_reg == vma_pkg::B_UPDATE)
                        wr_pend_reg <= add_en;
                    // advance to the next vertex and variant
                    slot_reg <= slot_reg + vma_pkg::SLOT_W'(1);
                    if (k_reg == 2'(vma_pkg::NVAR - 1))
                    begin
                        k_reg <= '0;
                        v_reg <= v_reg + vma_pkg::VTX_W'(1);
                    end
                    else
                        k_reg <= k_reg + 2'd1;
                    if (state_reg == vma_pkg::B_OUT && last_slot)
                    begin
                        vcnt_reg  <= '0;
                        valid_reg <= '0;
                    end
                end
                vma_pkg::B_NONE:
                begin
                    vcnt_reg  <= '0;
                    valid_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        valid_q_reg <= valid_reg[slot_reg];
        wr_slot_reg <= slot_reg;
        case (state_reg)
            vma_pkg::B_IDLE:
            begin
                if (pop)
                    item_reg <= head;
                if (pop && head.cmd == vma_pkg::CMD_LOAD &&
                    vcnt_reg < vma_pkg::VCNT_W'(vma_pkg::MAX_VERTICES))
                    vstore_reg[vcnt_reg[vma_pkg::VTX_W-1:0]] <= head.vertex_z;
            end
            vma_pkg::B_SEARCH:
            begin
                // strict compare keeps the lower index on a tie
                if (v_reg == '0 || dz_abs < bd_reg)
                begin
                    bd_reg   <= dz_abs;
                    best_reg <= v_reg;
                end
            end
            vma_pkg::B_EMIT_NEG:
            begin
                mx_reg     <= vma_pkg::sat_neg(s_x);
                my_reg     <= vma_pkg::sat_neg(s_y);
                mz_reg     <= vma_pkg::sat_neg(s_z);
                pt_out_reg <= s_pt;
            end
            vma_pkg::B_EMIT_SQ:
            begin
                sq_x_reg <= mx_reg * mx_reg;
                sq_y_reg <= my_reg * my_reg;
            end
            vma_pkg::B_EMIT_SUM:
            begin
                n_reg    <= vma_pkg::SQ_W'(sq_x_reg) + vma_pkg::SQ_W'(sq_y_reg);
                root_reg <= '0;
                rem_reg  <= '0;
                iter_reg <= '0;
            end
            vma_pkg::B_ROOT:
            begin
                // one root bit per cycle, restoring method
                n_reg    <= {n_reg[vma_pkg::SQ_W-3:0], 2'b00};
                iter_reg <= iter_reg + vma_pkg::ITER_W'(1);
                if (rem_shift >= trial)
                begin
                    rem_reg  <= rem_shift - trial;
                    root_reg <= {root_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[SW-2:0], 1'b0};
                end
            end
            vma_pkg::B_OUT:
            begin
                vertex_index <= 4'(v_reg);
                variant      <= k_reg;
                miss_x       <= mx_reg;
                miss_y       <= my_reg;
                miss_z       <= mz_reg;
                miss_mag     <= root_reg;
                scalar_sum   <= pt_out_reg;
                status       <= vma_pkg::STATUS_OK;
                last         <= last_slot;
            end
            vma_pkg::B_NONE:
            begin
                vertex_index <= '0;
                variant      <= vma_pkg::VAR_FULL;
                miss_x       <= '0;
                miss_y       <= '0;
                miss_z       <= '0;
                miss_mag     <= '0;
                scalar_sum   <= '0;
                status       <= vma_pkg::STATUS_NO_VERTEX;
                last         <= 1'b1;
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for more than one cycle");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status) |-> last)
        else $error("no-vertex result not marked last");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> (vcnt_reg == '0 && valid_reg == '0))
        else $error("state not cleared after final result");

    a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> $past(state_reg) == vma_pkg::B_UPDATE)
        else $error("sum write outside of update pass");
`endif

endmodule

### sv/vertex_met_accumulator.sv
`timescale 1ns / 1ps
// A load stores a vertex z; a neutral candidate walks the three sum-memory slots of each
// loaded vertex, and a charged one first searches the loaded vertices for the nearest in z.
// An emit gives its results one after another, each from the 28-step bit-serial square root.
// A two-entry queue takes commands while the back end works; busy is high when it is full.
// Results strobe for one cycle and cannot be stalled. Reset clears the vertex count,
// the queue and the per-slot valid bits at once; no clearing pass is run.
module vertex_met_accumulator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    cmd,
    input  logic signed [15:0]            vertex_z,
    input  logic signed [15:0]            cand_px,
    input  logic signed [15:0]            cand_py,
    input  logic signed [15:0]            cand_pz,
    input  logic [15:0]                   cand_pt,
    input  logic signed [10:0]            cand_eta,
    input  logic                          is_charged,
    input  logic signed [15:0]            cand_z,
    input  logic                          cfg_we,
    input  logic [vma_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vma_pkg::CFG_W-1:0]     cfg_data,
    output logic                          result_valid,
    output logic [3:0]                    vertex_index,
    output logic [1:0]                    variant,
    output logic signed [27:0]            miss_x,
    output logic signed [27:0]            miss_y,
    output logic signed [27:0]            miss_z,
    output logic [27:0]                   miss_mag,
    output logic [27:0]                   scalar_sum,
    output logic                          status,
    output logic                          last
);

    // front to queue
    logic               push;
    vma_pkg::item_t     push_item;
    // queue to back
    vma_pkg::item_t     head;
    vma_pkg::q_status_t q_status;
    logic               pop;

    // Accept and classify each transaction; the neutral track cuts are
    // evaluated here against the current configuration.
    vma_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .vertex_z   (vertex_z),
        .cand_px    (cand_px),
        .cand_py    (cand_py),
        .cand_pz    (cand_pz),
        .cand_pt    (cand_pt),
        .cand_eta   (cand_eta),
        .is_charged (is_charged),
        .cand_z     (cand_z),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_status   (q_status),
        .busy       (busy),
        .push       (push),
        .push_item  (push_item)
    );

    // Hold accepted transactions until the back end is free.
    vma_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // Walk the loaded vertices for search, sum update and emit.
    vma_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .vertex_index (vertex_index),
        .variant      (variant),
        .miss_x       (miss_x),
        .miss_y       (miss_y),
        .miss_z       (miss_z),
        .miss_mag     (miss_mag),
        .scalar_sum   (scalar_sum),
        .status       (status),
        .last         (last)
    );

endmodule

### verif/tb_vertex_met_accumulator.sv
`timescale 1ns / 1ps
// Self-checking testbench for vertex_met_accumulator: drives load, candidate and emit
// commands and checks every emitted result against an in-bench predictor.
// Depends on vma_pkg and the vertex_met_accumulator RTL.
module tb_vertex_met_accumulator;

    localparam int STALL_LIMIT = 20000;  // cycles with no transaction before giving up
    localparam int SETTLE      = 300;    // settle time after the last expected result has been seen

    typedef struct {
        vma_pkg::cmd_t      cmd;
        logic signed [15:0] vz;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic [15:0]        pt;
        logic signed [10:0] eta;
        logic               charged;
        logic signed [15:0] cz;
    } met_cmd_t;

    typedef struct packed {
        logic [3:0]         vidx;
        logic [1:0]         var_id;
        logic signed [27:0] mx;
        logic signed [27:0] my;
        logic signed [27:0] mz;
        logic [27:0]        mag;
        logic [27:0]        sum;
        logic               stat;
        logic               fin;
    } met_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] cmd = '0;
    logic signed [15:0] vertex_z = '0;
    logic signed [15:0] cand_px = '0;
    logic signed [15:0] cand_py = '0;
    logic signed [15:0] cand_pz = '0;
    logic [15:0] cand_pt = '0;
    logic signed [10:0] cand_eta = '0;
    logic is_charged = 1'b0;
    logic signed [15:0] cand_z = '0;
    logic cfg_we = 1'b0;
    logic [vma_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [vma_pkg::CFG_W-1:0] cfg_data = '0;
    logic result_valid;
    logic [3:0] vertex_index;
    logic [1:0] variant;
    logic signed [27:0] miss_x, miss_y, miss_z;
    logic [27:0] miss_mag, scalar_sum;
    logic status, last;

    vertex_met_accumulator dut (.*);

    // Free-running 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Commands waiting to be driven and the results the predictor expects.
    met_cmd_t    pending_cmds[$];
    met_result_t met_expected[$];
    met_cmd_t    cur_cmd;
    bit          presenting = 0;
    int          idle_pct = 0;
    int          mismatches = 0;
    int          stall_cycles = 0;

    // Predictor copy of the block's registers and accumulators.
    logic [15:0]         dz_cut_r, min_pt_r;
    logic [9:0]          max_eta_r;
    logic signed [15:0]  vtx_z[vma_pkg::MAX_VERTICES];
    int                  vtx_count;
    longint              acc_x[vma_pkg::NSLOT], acc_y[vma_pkg::NSLOT];
    longint              acc_z[vma_pkg::NSLOT], acc_pt[vma_pkg::NSLOT];

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mag_abs(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    task automatic queue_cmd(met_cmd_t m);
        pending_cmds.insert(pending_cmds.size(), m);
    endtask

    task automatic clear_sums();
        vtx_count = 0;
        for (int s = 0; s < vma_pkg::NSLOT; s++)
        begin
            acc_x[s] = 0; acc_y[s] = 0; acc_z[s] = 0; acc_pt[s] = 0;
        end
    endtask

    task automatic add_to_slot(int s, met_cmd_t c);
        acc_x[s]  = clip(acc_x[s] + longint'(c.px), -134217728, 134217727);
        acc_y[s]  = clip(acc_y[s] + longint'(c.py), -134217728, 134217727);
        acc_z[s]  = clip(acc_z[s] + longint'(c.pz), -134217728, 134217727);
        acc_pt[s] = clip(acc_pt[s] + longint'(c.pt), 0, 268435455);
    endtask

    // Advance the predictor by one accepted transaction.
    task automatic accumulate_cmd(met_cmd_t c);
        met_result_t r;
        longint      mx, my, mz, d, bd;
        int          best;
        bit          tk;
        case (c.cmd)
            vma_pkg::CMD_LOAD:
                if (vtx_count < vma_pkg::MAX_VERTICES)
                begin
                    vtx_z[vtx_count] = c.vz;
                    vtx_count++;
                end
            vma_pkg::CMD_CAND:
                if (vtx_count > 0)
                begin
                    for (int v = 0; v < vtx_count; v++)
                        add_to_slot(v * vma_pkg::NVAR + int'(vma_pkg::VAR_FULL), c);
                    if (!c.charged)
                    begin
                        tk = c.pt > min_pt_r &&
                             mag_abs(longint'(c.eta)) < longint'(max_eta_r);
                        for (int v = 0; v < vtx_count; v++)
                        begin
                            if (tk)
                                add_to_slot(v * vma_pkg::NVAR + int'(vma_pkg::VAR_TRACK), c);
                            add_to_slot(v * vma_pkg::NVAR + int'(vma_pkg::VAR_NOPU), c);
                        end
                    end
                    else
                    begin
                        // nearest vertex in z; strict compare keeps ties on the lower index
                        best = 0;
                        bd = mag_abs(longint'(c.cz) - longint'(vtx_z[0]));
                        for (int v = 1; v < vtx_count; v++)
                        begin
                            d = mag_abs(longint'(c.cz) - longint'(vtx_z[v]));
                            if (d < bd)
                            begin
                                bd = d;
                                best = v;
                            end
                        end
                        if (bd < longint'(dz_cut_r))
                        begin
                            add_to_slot(best * vma_pkg::NVAR + int'(vma_pkg::VAR_TRACK), c);
                            add_to_slot(best * vma_pkg::NVAR + int'(vma_pkg::VAR_NOPU), c);
                        end
                    end
                end
            vma_pkg::CMD_EMIT:
            begin
                if (vtx_count == 0)
                begin
                    r = '0;
                    r.stat = vma_pkg::STATUS_NO_VERTEX;
                    r.fin = 1'b1;
                    met_expected.insert(met_expected.size(), r);
                end
                for (int v = 0; v < vtx_count; v++)
                    for (int k = 0; k < vma_pkg::NVAR; k++)
                    begin
                        mx = clip(-acc_x[v * vma_pkg::NVAR + k], -134217728, 134217727);
                        my = clip(-acc_y[v * vma_pkg::NVAR + k], -134217728, 134217727);
                        mz = clip(-acc_z[v * vma_pkg::NVAR + k], -134217728, 134217727);
                        r.vidx   = v[3:0];
                        r.var_id = k[1:0];
                        r.mx     = mx[27:0];
                        r.my     = my[27:0];
                        r.mz     = mz[27:0];
                        r.mag    = 28'(floor_sqrt(longint'(mx * mx + my * my)));
                        r.sum    = acc_pt[v * vma_pkg::NVAR + k][27:0];
                        r.stat   = vma_pkg::STATUS_OK;
                        r.fin    = (v == vtx_count - 1 && k == vma_pkg::NVAR - 1);
                        met_expected.insert(met_expected.size(), r);
                    end
                clear_sums();
            end
            default: ;  // unused command: no effect
        endcase
    endtask

    // Driver: hold the current transaction until accepted, then present the next one.
    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            accumulate_cmd(cur_cmd);
            presenting = 0;
        end
        if (!presenting)
        begin
            if (rst_n && pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                cur_cmd = pending_cmds.pop_front();
                presenting = 1;
                cmd        <= cur_cmd.cmd;
                vertex_z   <= cur_cmd.vz;
                cand_px    <= cur_cmd.px;
                cand_py    <= cur_cmd.py;
                cand_pz    <= cur_cmd.pz;
                cand_pt    <= cur_cmd.pt;
                cand_eta   <= cur_cmd.eta;
                is_charged <= cur_cmd.charged;
                cand_z     <= cur_cmd.cz;
                start      <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: results cannot be stalled, so check each strobe against the oldest expectation.
    always @(posedge clk)
    begin
        met_result_t got, want;
        if (result_valid)
        begin
            got = {vertex_index, variant, miss_x, miss_y, miss_z, miss_mag, scalar_sum,
                   status, last};
            if (met_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: vtx %0d var %0d", vertex_index, variant);
            end
            else
            begin
                want = met_expected.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result mismatch");
                        $display("  exp vtx %0d var %0d x %0d y %0d z %0d mag %0d sum %0d %s",
                                 want.vidx, want.var_id, want.mx, want.my, want.mz,
                                 want.mag, want.sum, "");
                        $display("      st %0b last %0b", want.stat, want.fin);
                        $display("  got vtx %0d var %0d x %0d y %0d z %0d mag %0d sum %0d %s",
                                 got.vidx, got.var_id, got.mx, got.my, got.mz,
                                 got.mag, got.sum, "");
                        $display("      st %0b last %0b", got.stat, got.fin);
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no transaction of any kind happens.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_vertex_met_accumulator: FAIL");
            $finish;
        end
    end

    function automatic met_cmd_t blank_cmd(vma_pkg::cmd_t c);
        met_cmd_t m;
        m.cmd = c; m.vz = '0; m.px = '0; m.py = '0; m.pz = '0;
        m.pt = '0; m.eta = '0; m.charged = 1'b0; m.cz = '0;
        return m;
    endfunction

    task automatic push_load(logic signed [15:0] z);
        met_cmd_t m;
        m = blank_cmd(vma_pkg::CMD_LOAD);
        m.vz = z;
        queue_cmd(m);
    endtask

    task automatic push_cand(logic signed [15:0] px, logic signed [15:0] py,
                             logic signed [15:0] pz, logic [15:0] pt,
                             logic signed [10:0] eta, logic ch, logic signed [15:0] cz);
        met_cmd_t m;
        m = blank_cmd(vma_pkg::CMD_CAND);
        m.px = px; m.py = py; m.pz = pz; m.pt = pt; m.eta = eta; m.charged = ch; m.cz = cz;
        queue_cmd(m);
    endtask

    task automatic push_random_cand(logic signed [15:0] near_z);
        logic signed [15:0] cz;
        cz = 16'($urandom());
        // steer most charged candidates close to a loaded vertex so the dz cut matters
        if ($urandom_range(9) < 7)
            cz = near_z + 16'($signed($urandom_range(400)) - 200);
        push_cand(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  11'($urandom()), 1'($urandom_range(1)), cz);
    endtask

    // Wait until the block has gone quiet; loads and candidates give no result to wait on.
    task automatic drain();
        while (pending_cmds.size() > 0 || presenting || met_expected.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [vma_pkg::CFG_IDX_W-1:0] idx,
                             logic [vma_pkg::CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            vma_pkg::CFG_DZ_CUT:  dz_cut_r  = data;
            vma_pkg::CFG_MIN_PT:  min_pt_r  = data;
            vma_pkg::CFG_MAX_ETA: max_eta_r = data[9:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random frames: loads, candidates, an emit; some frames left empty or overfilled.
    task automatic random_frames(int n_items);
        int pushed, nv, nc;
        logic signed [15:0] zs[vma_pkg::MAX_VERTICES + 3];
        pushed = 0;
        while (pushed < n_items)
        begin
            case ($urandom_range(19))
                0:       nv = 0;
                1:       nv = vma_pkg::MAX_VERTICES + int'($urandom_range(2));
                2, 3:    nv = int'($urandom_range(vma_pkg::MAX_VERTICES));
                default: nv = 1 + int'($urandom_range(3));
            endcase
            for (int i = 0; i < nv; i++)
            begin
                zs[i] = 16'($urandom());
                push_load(zs[i]);
            end
            nc = int'($urandom_range(12));
            for (int i = 0; i < nc; i++)
            begin
                if ($urandom_range(19) == 0)
                    queue_cmd(blank_cmd(vma_pkg::CMD_NOP));
                push_random_cand(nv > 0 ? zs[$urandom_range(nv - 1)] : 16'sd0);
            end
            queue_cmd(blank_cmd(vma_pkg::CMD_EMIT));
            pushed += nv + nc + 1;
        end
    endtask

    initial
    begin
        dz_cut_r  = vma_pkg::DZ_CUT_RESET;
        min_pt_r  = vma_pkg::MIN_PT_RESET;
        max_eta_r = vma_pkg::MAX_ETA_RESET;
        clear_sums();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset configuration, empty emit, orphan candidate, unused command.
        queue_cmd(blank_cmd(vma_pkg::CMD_EMIT));
        push_cand(16'sd5, 16'sd6, 16'sd7, 16'd8, 11'sd0, 1'b0, 16'sd0);
        queue_cmd(blank_cmd(vma_pkg::CMD_NOP));
        push_load(16'sd0);
        push_load(16'sd100);
        push_load(-16'sd32768);
        push_load(16'sd32767);
        push_cand(16'sd10, -16'sd20, 16'sd30, 16'd40, 11'sd3, 1'b1, 16'sd50);     // z tie
        push_cand(16'sd1, 16'sd1, 16'sd1, 16'd1, 11'sd0, 1'b1, 16'sd200);         // dz equal
        push_cand(16'sd32767, -16'sd32768, 16'sd32767, 16'd65535, 11'sd0, 1'b1,
                  16'sd32767);
        push_cand(16'sd3, 16'sd4, 16'sd0, 16'd0, 11'sd0, 1'b0, 16'sd0);          // pt at cut
        push_cand(16'sd3, 16'sd4, 16'sd0, 16'd5, -11'sd1024, 1'b0, 16'sd0);     // eta out
        push_cand(-16'sd7, 16'sd9, -16'sd11, 16'd1, 11'sd1022, 1'b0, 16'sd0);
        queue_cmd(blank_cmd(vma_pkg::CMD_EMIT));
        for (int i = 0; i < vma_pkg::MAX_VERTICES + 1; i++)   // one load past a full store
            push_load(16'(i * 37 - 300));
        push_cand(16'sd100, 16'sd200, 16'sd300, 16'd400, 11'sd10, 1'b1, 16'sd292);
        queue_cmd(blank_cmd(vma_pkg::CMD_EMIT));
        drain();

        // Random phases across register settings and sender idling.
        write_reg(vma_pkg::CFG_DZ_CUT, 16'd0);
        write_reg(vma_pkg::CFG_MIN_PT, 16'd65535);
        write_reg(vma_pkg::CFG_MAX_ETA, 16'd0);
        idle_pct = 0;
        random_frames(60);
        drain();

        write_reg(vma_pkg::CFG_DZ_CUT, 16'd65535);
        write_reg(vma_pkg::CFG_MIN_PT, 16'd0);
        write_reg(vma_pkg::CFG_MAX_ETA, 16'd1023);
        idle_pct = 84;
        random_frames(70);
        drain();

        write_reg(vma_pkg::CFG_DZ_CUT, 16'($urandom_range(50, 300)));
        write_reg(vma_pkg::CFG_MIN_PT, 16'($urandom_range(65535)));
        write_reg(vma_pkg::CFG_MAX_ETA, 16'($urandom_range(1023)));
        idle_pct = 0;
        random_frames(70);
        drain();

        write_reg(vma_pkg::CFG_DZ_CUT, 16'd150);
        write_reg(vma_pkg::CFG_MIN_PT, 16'd20000);
        write_reg(vma_pkg::CFG_MAX_ETA, 16'd300);
        idle_pct = 24;
        random_frames(70);
        drain();

        if (mismatches == 0)
            $display("tb_vertex_met_accumulator: PASS");
        else
            $display("tb_vertex_met_accumulator: FAIL");
        $finish;
    end

endmodule

### filelist.f
sv/vma_pkg.sv
sv/vma_ram.sv
sv/vma_front.sv
sv/vma_queue.sv
sv/vma_back.sv
sv/vertex_met_accumulator.sv
verif/tb_vertex_met_accumulator.sv
